/* rtl/fwksd_pkg.sv */
`timescale 1ns / 1ps

package fwksd_pkg;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_FIND,
    CMD_DEL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [KEY_W-1:0]   key;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_POP,
    BS_SCAN,
    BS_SHIFT,
    BS_EMIT
  } back_state_t;

endpackage

/* rtl/fwksd_req_if.sv */
`timescale 1ns / 1ps

interface fwksd_req_if;
  import fwksd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key_in;

  modport source (output valid, output op, output key_in, input ready);
  modport sink (input valid, input op, input key_in, output ready);
endinterface

/* rtl/fwksd_rsp_if.sv */
`timescale 1ns / 1ps

interface fwksd_rsp_if;
  import fwksd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] key_out;
  logic [COUNT_W-1:0]      count;
  logic                    is_empty;

  modport source (output valid, output status, output key_out, output count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input key_out, input count,
                input is_empty, output ready);
endinterface

/* rtl/fwksd_ram.sv */
`timescale 1ns / 1ps

module fwksd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/fwksd_front.sv */
`timescale 1ns / 1ps

module fwksd_front (
  input  logic             clk,
  input  logic             rst,
  fwksd_req_if.sink        req,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output fwksd_pkg::cmd_t  cmd
);
  import fwksd_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_kind_t  kind;
  logic       push;
  logic       pop;

  always_comb begin
    case (req.op)
      OP_PUSH: kind = CMD_PUSH;
      OP_POP:  kind = CMD_POP;
      OP_FIND: kind = CMD_FIND;
      default: kind = CMD_DEL;
    endcase
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, key: req.key_in};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* rtl/fwksd_back.sv */
`timescale 1ns / 1ps

module fwksd_back #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  fwksd_pkg::cmd_t  cmd,
  fwksd_rsp_if.source      rsp
);
  import fwksd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  back_state_t         state;
  back_state_t         state_next;
  logic [PW-1:0]       head;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       last;
  logic [KEY_W-1:0]    cmd_key;
  cmd_kind_t           cmd_kind;
  logic [STATUS_W-1:0] res_status;
  logic [KEY_W-1:0]    res_key;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [KEY_W-1:0]    out_key;
  logic [COUNT_W-1:0]  out_count;
  logic                out_empty;
  logic                can_emit;

  logic                rd_en;
  logic [CW-1:0]       rd_lidx;
  logic [KEY_W-1:0]    rd_data;
  logic                wr_en;
  logic [CW-1:0]       wr_lidx;
  logic [KEY_W-1:0]    wr_data;
  logic                match;
  logic                full;
  logic                empty;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [CW-1:0] l);
    logic [PW:0] s;
    s = {1'b0, base} + (PW + 1)'(l);
    if (s >= (PW + 1)'(DEPTH)) begin
      s = s - (PW + 1)'(DEPTH);
    end
    return s[PW-1:0];
  endfunction

  assign last     = cnt - 1'b1;
  assign match    = (rd_data == cmd_key);
  assign full     = (cnt == CW'(DEPTH));
  assign empty    = (cnt == '0);
  assign can_emit = !out_valid || rsp.ready;

  fwksd_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (phys(head, wr_lidx)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (phys(head, rd_lidx)),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_PUSH: state_next = BS_EMIT;
            CMD_POP:  state_next = empty ? BS_EMIT : BS_POP;
            default:  state_next = empty ? BS_EMIT : BS_SCAN;
          endcase
        end
      end
      BS_POP: state_next = BS_EMIT;
      BS_SCAN: begin
        if (match) begin
          state_next = (cmd_kind == CMD_DEL && idx != last) ? BS_SHIFT : BS_EMIT;
        end else if (idx == '0) begin
          state_next = BS_EMIT;
        end
      end
      BS_SHIFT: begin
        if (idx + 1'b1 == last) begin
          state_next = BS_EMIT;
        end
      end
      BS_EMIT: begin
        if (can_emit) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    rd_en     = 1'b0;
    rd_lidx   = '0;
    wr_en     = 1'b0;
    wr_lidx   = cnt;
    wr_data   = cmd.key;
    case (state)
      BS_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          case (cmd.kind)
            CMD_PUSH: wr_en = !full;
            CMD_POP:  rd_en = !empty;
            default: begin
              rd_en   = !empty;
              rd_lidx = last;
            end
          endcase
        end
      end
      BS_SCAN: begin
        if (!match && idx != '0) begin
          rd_en   = 1'b1;
          rd_lidx = idx - 1'b1;
        end else if (match && cmd_kind == CMD_DEL && idx != last) begin
          rd_en   = 1'b1;
          rd_lidx = idx + 1'b1;
        end
      end
      BS_SHIFT: begin
        wr_en   = 1'b1;
        wr_lidx = idx;
        wr_data = rd_data;
        if (idx + 1'b1 != last) begin
          rd_en   = 1'b1;
          rd_lidx = idx + CW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_key    <= cmd.key;
          cmd_kind   <= cmd.kind;
          res_status <= (cmd.kind == CMD_PUSH) ? (full ? ST_FULL : ST_OK) : ST_MISS;
          res_key    <= '0;
          idx        <= last;
        end
      end
      BS_POP: begin
        res_status <= ST_OK;
        res_key    <= rd_data;
      end
      BS_SCAN: begin
        if (match) begin
          res_status <= ST_OK;
          res_key    <= cmd_key;
        end else if (idx != '0) begin
          idx <= idx - 1'b1;
        end
      end
      BS_SHIFT: begin
        if (idx + 1'b1 != last) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state == BS_EMIT && can_emit) begin
      out_status <= res_status;
      out_key    <= res_key;
      out_count  <= COUNT_W'(cnt);
      out_empty  <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      head      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BS_IDLE && cmd_valid && cmd.kind == CMD_PUSH && !full) begin
        cnt <= cnt + 1'b1;
      end
      if (state == BS_POP) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
        cnt  <= last;
      end
      if (state == BS_SCAN && match && cmd_kind == CMD_DEL && idx == last) begin
        cnt <= last;
      end
      if (state == BS_SHIFT && idx + 1'b1 == last) begin
        cnt <= last;
      end
      if (state == BS_EMIT && can_emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.key_out  = out_key;
  assign rsp.count    = out_count;
  assign rsp.is_empty = out_empty;

endmodule

/* rtl/fifo_with_key_search_delete_top.sv */
`timescale 1ns / 1ps

// Ordered key store of up to DEPTH entries with push, pop, find and delete-by-key requests.
// Requests enter a two-entry command queue and are carried out one at a time against a
// circular key memory with a single read port and a single write port; each request yields
// exactly one response. After a request reaches the executor, push writes its key, unless the
// store is full, and goes straight to the response, while pop first reads the oldest key. Find
// and delete scan the stored keys from newest to oldest, one per cycle through the memory read
// port. A delete then closes the gap by moving each newer entry down one place, one per cycle.
// No clearing pass is needed after reset.
module fifo_with_key_search_delete_top #(
  parameter int DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  fwksd_req_if.sink   req,
  fwksd_rsp_if.source rsp
);
  import fwksd_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  fwksd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fwksd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule
